// File: hdl/i2cbe_pkg.sv
// Shared types and constants for the I2C master bit engine.
package i2cbe_pkg;

  // Input kind codes as they arrive on the stream
  localparam logic [2:0] KIND_NONE  = 3'd0;
  localparam logic [2:0] KIND_START = 3'd1;
  localparam logic [2:0] KIND_STOP  = 3'd2;
  localparam logic [2:0] KIND_WRITE = 3'd3;
  localparam logic [2:0] KIND_READ  = 3'd4;
  localparam logic [2:0] KIND_SACK  = 3'd5;
  localparam logic [2:0] KIND_RACK  = 3'd6;

  // Phase counts per command
  localparam logic [4:0] BYTE_PHASES = 5'd16;
  localparam logic [4:0] BIT_PHASES  = 5'd2;

  localparam int         HP_W     = 16;
  localparam logic [HP_W-1:0] HP_RESET = 16'd250;

  // Queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int IN_DATA_W  = 16;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 16;

  // Running command, one-hot
  typedef enum logic [6:0] {
    CMD_IDLE  = 7'b0000001,
    CMD_START = 7'b0000010,
    CMD_STOP  = 7'b0000100,
    CMD_WRITE = 7'b0001000,
    CMD_READ  = 7'b0010000,
    CMD_SACK  = 7'b0100000,
    CMD_RACK  = 7'b1000000
  } cmd_t;

  // Classified tick word handed from front to back
  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] tx_byte;
    logic       ack_bit;
    logic       sda_in;
  } tick_t;

  // Queue status seen by the back end
  typedef struct packed {
    logic  valid;
    tick_t word;
  } q_head_t;

endpackage

// File: hdl/i2cbe_front.sv
// Front end: decodes incoming ticks and queues them for the bit engine.
module i2cbe_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [i2cbe_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [i2cbe_pkg::IN_USER_W-1:0]  in_tuser,
  output i2cbe_pkg::q_head_t               q_head,
  input  logic                             q_pop
);
  import i2cbe_pkg::*;

  tick_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  tick_t             word;
  logic              push;

  always_comb begin
    case (in_tuser)
      KIND_START: word.cmd = CMD_START;
      KIND_STOP:  word.cmd = CMD_STOP;
      KIND_WRITE: word.cmd = CMD_WRITE;
      KIND_READ:  word.cmd = CMD_READ;
      KIND_SACK:  word.cmd = CMD_SACK;
      KIND_RACK:  word.cmd = CMD_RACK;
      default:    word.cmd = CMD_IDLE;  // none, or unused code
    endcase
    word.tx_byte = in_tdata[7:0];
    word.ack_bit = in_tdata[8];
    word.sda_in  = in_tdata[9];
  end

  assign in_tready = (count_r != QCNT_W'(QDEPTH));
  assign push      = in_tvalid && in_tready;

  always_comb begin
    wr_ptr_nxt = push  ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= word;
    end
  end

  assign q_head.valid = (count_r != '0);
  assign q_head.word  = mem_r[rd_ptr_r];

endmodule

// File: hdl/i2cbe_back.sv
// Back end: I2C bit sequencer, half-period timer and result register.
module i2cbe_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [i2cbe_pkg::HP_W-1:0]        cfg_wdata,
  input  i2cbe_pkg::q_head_t                q_head,
  output logic                              q_pop,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [i2cbe_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import i2cbe_pkg::*;

  logic [HP_W-1:0] hp_r;
  cmd_t            cmd_r, cmd_nxt;
  logic [4:0]      phase_r, phase_nxt;
  logic [HP_W-1:0] timer_r, timer_nxt;
  logic [7:0]      shift_r, shift_nxt;
  logic            scl_r, scl_nxt;
  logic            sda_r, sda_nxt;
  logic            ack_r, ack_nxt;
  logic [7:0]      rx_r, rx_nxt;
  logic            out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic [HP_W-1:0] hp;
  logic [4:0]      phases;
  logic            done;
  logic            enter;
  logic            reading;
  tick_t           w;

  assign w     = q_head.word;
  assign q_pop = q_head.valid && (!out_valid_r || out_tready);
  assign hp    = (hp_r == '0) ? HP_W'(1) : hp_r;
  assign phases = (cmd_r == CMD_WRITE || cmd_r == CMD_READ) ? BYTE_PHASES : BIT_PHASES;

  always_comb begin
    cmd_nxt   = cmd_r;
    phase_nxt = phase_r;
    timer_nxt = timer_r;
    shift_nxt = shift_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    ack_nxt   = ack_r;
    rx_nxt    = rx_r;
    done      = 1'b0;
    enter     = 1'b0;
    if (q_pop) begin
      if (cmd_r != CMD_IDLE) begin
        timer_nxt = timer_r + HP_W'(1);
        if (timer_nxt >= hp) begin
          timer_nxt = '0;
          // end of an SCL high phase: shift or sample
          if (phase_r[0]) begin
            case (cmd_r)
              CMD_WRITE, CMD_SACK: shift_nxt = {shift_r[6:0], 1'b0};
              CMD_READ:            shift_nxt = {shift_r[6:0], w.sda_in};
              CMD_RACK:            ack_nxt   = w.sda_in;
              default:             ;
            endcase
          end
          phase_nxt = phase_r + 5'd1;
          if (phase_nxt >= phases) begin
            if (cmd_r == CMD_STOP) sda_nxt = 1'b1;
            else                   scl_nxt = 1'b0;
            if (cmd_r == CMD_READ) rx_nxt = shift_nxt;
            cmd_nxt   = CMD_IDLE;
            phase_nxt = '0;
            timer_nxt = '0;
            done      = 1'b1;
          end else begin
            enter = 1'b1;
          end
        end
      end else if (w.cmd != CMD_IDLE) begin
        cmd_nxt   = w.cmd;
        phase_nxt = '0;
        timer_nxt = '0;
        case (w.cmd)
          CMD_WRITE: shift_nxt = w.tx_byte;
          CMD_SACK:  shift_nxt = {w.ack_bit, 7'd0};
          CMD_READ:  shift_nxt = '0;
          default:   ;
        endcase
        enter = 1'b1;
      end
      if (enter) begin
        case (cmd_nxt)
          CMD_START: begin
            scl_nxt = 1'b1;
            sda_nxt = (phase_nxt == '0);
          end
          CMD_STOP: begin
            sda_nxt = 1'b0;
            scl_nxt = (phase_nxt != '0);
          end
          default: begin
            if (!phase_nxt[0]) begin
              scl_nxt = 1'b0;
              sda_nxt = (cmd_nxt == CMD_READ || cmd_nxt == CMD_RACK) ? 1'b1 : shift_nxt[7];
            end else begin
              scl_nxt = 1'b1;
            end
          end
        endcase
      end
    end
  end

  assign reading = (cmd_nxt == CMD_READ) || (cmd_nxt == CMD_RACK);

  always_comb begin
    out_data_nxt        = '0;
    out_data_nxt[0]     = scl_nxt;
    out_data_nxt[1]     = sda_nxt;
    out_data_nxt[2]     = reading;
    out_data_nxt[3]     = (cmd_nxt != CMD_IDLE);
    out_data_nxt[4]     = done;
    out_data_nxt[12:5]  = rx_nxt;
    out_data_nxt[13]    = ack_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hp_r        <= HP_RESET;
      cmd_r       <= CMD_IDLE;
      phase_r     <= '0;
      timer_r     <= '0;
      shift_r     <= '0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      ack_r       <= 1'b0;
      rx_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) hp_r <= cfg_wdata;
      cmd_r   <= cmd_nxt;
      phase_r <= phase_nxt;
      timer_r <= timer_nxt;
      shift_r <= shift_nxt;
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
      ack_r   <= ack_nxt;
      rx_r    <= rx_nxt;
      if (q_pop)           out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: hdl/i2c_master_bit_engine.sv
// Top level of the I2C master bit engine: front queue plus bit sequencer.
//
// One input word is one tick of the bit timer; every accepted word yields
// exactly one result word, in order. The block takes one word per clock
// cycle when the result side keeps up. A word crosses the front decoder
// into a two-entry queue, and the back end retires one queued word per
// cycle into the output register while that register is empty or being
// taken. An accepted word is stored in the queue, and the back end then
// loads its result into the output register that drives out_tdata. The
// back end updates its state (timer, phase, shift register) once for each
// word it retires. A stalled result side fills the queue (two words)
// behind the output register (one word), after which in_tready drops. A
// command (start, stop, write byte, read byte, send ack, read ack) is taken
// only while the engine is idle; each of its phases lasts half_period_ticks
// ticks (zero counts as one). cfg_wdata sets half_period_ticks (reset 250).
// The user must write it only while no word is in flight in the queue or
// the output register; the block itself does not enforce this. A write
// that lands in the middle of a phase ends that phase as soon as its
// elapsed ticks reach the new value.
module i2c_master_bit_engine (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: half_period_ticks
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  // input ticks
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] tx_byte, [8] ack_bit, [9] sda_in, rest zero
  input  logic [2:0]  in_tuser,   // [2:0] kind
  // results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [0] scl_level, [1] sda_level, [2] sda_reading,
                                  // [3] busy_res, [4] done_res, [12:5] rx_byte,
                                  // [13] rx_nack, rest zero
);
  import i2cbe_pkg::*;

  q_head_t q_head;   // head of the tick queue
  logic    q_pop;    // back end retires the head word

  i2cbe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_head    (q_head),
    .q_pop     (q_pop)
  );

  i2cbe_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// File: verif/tb_top.sv
// Self-checking stream testbench for the I2C master bit engine.
module tb_top;
  import i2cbe_pkg::*;

  // Kind seven is not a command; the engine must ignore it
  localparam logic [2:0] KIND_RESERVED = 3'd7;
  // Result path is the queue and the output register; leave margin before a config write
  localparam int DRAIN_CYCLES   = 8;
  // Cycles without any handshake or config write before the run is declared hung
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RX_HOLD_CYCLES = 80;
  localparam int RANDOM_TICKS   = 190;

  // Result word as packed on out_tdata[13:0], top field first
  typedef struct packed {
    logic       rx_nack;
    logic [7:0] rx_byte;
    logic       done;
    logic       busy;
    logic       reading;
    logic       sda;
    logic       scl;
  } bus_status_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // [7:0] tx_byte, [8] ack_bit, [9] sda_in
  logic [2:0]  in_tuser = '0;   // [2:0] kind
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // [0] scl, [1] sda, [2] reading, [3] busy,
                                // [4] done, [12:5] rx_byte, [13] rx_nack

  // Predicted engine state, updated once per accepted input word
  logic [15:0] m_half_period = HP_RESET;
  logic [2:0]  m_cmd = KIND_NONE;
  logic [4:0]  m_phase = '0;
  logic [15:0] m_timer = '0;
  logic [7:0]  m_shift = '0;
  logic        m_scl = 1'b1;
  logic        m_sda = 1'b1;
  logic        m_ack = 1'b0;
  logic [7:0]  m_rx = '0;

  bus_status_t expected_status_q [$];

  int  ticks_sent = 0;
  int  commands_issued = 0;
  int  status_checked = 0;
  int  mismatches = 0;
  int  quiet_cycles = 0;
  int  half_period_writes = 0;
  bit  sender_full_rate = 1'b0;
  bit  receiver_full_rate = 1'b0;
  bit  rx_hold_req = 1'b0;
  int unsigned rx_hold_left = 0;

  i2c_master_bit_engine i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Bus levels on entry to phase p of the running command
  function automatic void drive_phase(input logic [4:0] p);
    if (m_cmd == KIND_START) begin
      m_scl = 1'b1;
      m_sda = (p == 5'd0);
    end else if (m_cmd == KIND_STOP) begin
      m_sda = 1'b0;
      m_scl = (p != 5'd0);
    end else if (!p[0]) begin
      // low half of a bit: release SDA for reads, else put out the MSB
      m_scl = 1'b0;
      m_sda = (m_cmd == KIND_READ || m_cmd == KIND_RACK) ? 1'b1 : m_shift[7];
    end else begin
      m_scl = 1'b1;
    end
  endfunction

  // One timer tick: advance the engine and return the status it shows
  function automatic bus_status_t bit_engine_step(input logic [2:0] kind,
                                                  input logic [7:0] tx,
                                                  input logic ackb,
                                                  input logic sda_in);
    logic [15:0] hp;
    logic [4:0]  phase_total;
    bus_status_t s;
    hp = (m_half_period == 16'd0) ? 16'd1 : m_half_period;
    s = '0;
    if (m_cmd != KIND_NONE) begin
      // busy: the word's kind is ignored, only the timer and SDA count
      m_timer = m_timer + 16'd1;
      if (m_timer >= hp) begin
        m_timer = '0;
        if (m_phase[0]) begin
          // end of a high half: shift out or sample
          case (m_cmd)
            KIND_WRITE, KIND_SACK: m_shift = {m_shift[6:0], 1'b0};
            KIND_READ:             m_shift = {m_shift[6:0], sda_in};
            KIND_RACK:             m_ack = sda_in;
            default: ;
          endcase
        end
        m_phase = m_phase + 5'd1;
        phase_total = (m_cmd == KIND_WRITE || m_cmd == KIND_READ) ? BYTE_PHASES : BIT_PHASES;
        if (m_phase >= phase_total) begin
          if (m_cmd == KIND_STOP) m_sda = 1'b1;
          else m_scl = 1'b0;
          if (m_cmd == KIND_READ) m_rx = m_shift;
          m_cmd = KIND_NONE;
          m_phase = '0;
          m_timer = '0;
          s.done = 1'b1;
        end else begin
          drive_phase(m_phase);
        end
      end
    end else if (kind >= KIND_START && kind <= KIND_RACK) begin
      m_cmd = kind;
      m_phase = '0;
      m_timer = '0;
      case (kind)
        KIND_WRITE: m_shift = tx;
        KIND_SACK:  m_shift = {ackb, 7'd0};
        KIND_READ:  m_shift = '0;
        default: ;
      endcase
      drive_phase(5'd0);
    end
    s.scl     = m_scl;
    s.sda     = m_sda;
    s.reading = (m_cmd == KIND_READ || m_cmd == KIND_RACK);
    s.busy    = (m_cmd != KIND_NONE);
    s.rx_byte = m_rx;
    s.rx_nack = m_ack;
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: ready pattern, long hold-off on request, and the checker
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
      out_tready <= 1'b0;
    end else if (rx_hold_req) begin
      // hold off long enough for the internal queue to fill and in_tready to drop
      rx_hold_req = 1'b0;
      rx_hold_left <= RX_HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= receiver_full_rate || ($urandom_range(99) >= 26);
    end
  end

  always @(posedge clk) begin : status_check
    bus_status_t got;
    bus_status_t want;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      got = out_tdata[13:0];
      if (expected_status_q.size() == 0) begin
        $error("result word with no expectation pending: %h", out_tdata);
        mismatches++;
      end else begin
        want = expected_status_q.pop_front();
        status_checked++;
        if (got.scl !== want.scl) begin
          $error("scl_level: expected %0d, got %0d", want.scl, got.scl);
          mismatches++;
        end
        if (got.sda !== want.sda) begin
          $error("sda_level: expected %0d, got %0d", want.sda, got.sda);
          mismatches++;
        end
        if (got.reading !== want.reading) begin
          $error("sda_reading: expected %0d, got %0d", want.reading, got.reading);
          mismatches++;
        end
        if (got.busy !== want.busy) begin
          $error("busy_res: expected %0d, got %0d", want.busy, got.busy);
          mismatches++;
        end
        if (got.done !== want.done) begin
          $error("done_res: expected %0d, got %0d", want.done, got.done);
          mismatches++;
        end
        if (got.rx_byte !== want.rx_byte) begin
          $error("rx_byte: expected %h, got %h", want.rx_byte, got.rx_byte);
          mismatches++;
        end
        if (got.rx_nack !== want.rx_nack) begin
          $error("rx_nack: expected %0d, got %0d", want.rx_nack, got.rx_nack);
          mismatches++;
        end
        if (out_tdata[15:14] !== 2'b00) begin
          $error("pad bits: expected 0, got %b", out_tdata[15:14]);
          mismatches++;
        end
      end
    end
  end

  // Hang detector: any handshake or config write counts as progress
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offer one tick word, with random gaps unless at full rate, and predict it once accepted
  task automatic send_tick(input logic [2:0] kind, input logic [7:0] tx,
                           input logic ackb, input logic sda_in);
    if (!sender_full_rate) begin
      while ($urandom_range(99) < 26) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {6'd0, sda_in, ackb, tx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_status_q.push_back(bit_engine_step(kind, tx, ackb, sda_in));
    ticks_sent++;
  endtask

  // Word with any kind; the engine is busy so the kind must be dropped
  task automatic noise_tick(input int sda_bias);
    send_tick(3'($urandom_range(7)), 8'($urandom_range(255)), 1'($urandom_range(1)),
              $urandom_range(99) < sda_bias);
  endtask

  task automatic idle_ticks(input int n);
    repeat (n)
      send_tick($urandom_range(1) ? KIND_NONE : KIND_RESERVED, 8'($urandom_range(255)),
                1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  task automatic issue_command(input logic [2:0] kind, input logic [7:0] tx,
                               input logic ackb);
    send_tick(kind, tx, ackb, 1'($urandom_range(1)));
    if (m_cmd != KIND_NONE) commands_issued++;
  endtask

  // sda_bias: percent chance that the line reads high on each tick
  task automatic finish_command(input int sda_bias);
    while (m_cmd != KIND_NONE) noise_tick(sda_bias);
  endtask

  task automatic run_command(input logic [2:0] kind, input logic [7:0] tx,
                             input logic ackb, input int sda_bias);
    issue_command(kind, tx, ackb);
    finish_command(sda_bias);
  endtask

  // Stop offering and wait until every result word is back
  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_status_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_half_period(input logic [15:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    m_half_period = value;
    half_period_writes++;
  endtask

  // Well-formed transfer: start, address, ack, data bytes with acks, stop
  task automatic bus_transaction();
    logic rd;
    int   nbytes;
    rd = 1'($urandom_range(1));
    nbytes = $urandom_range(1, 3);
    run_command(KIND_START, 8'($urandom_range(255)), 1'($urandom_range(1)), 50);
    run_command(KIND_WRITE, {7'($urandom_range(127)), rd}, 1'b0, 50);
    run_command(KIND_RACK, 8'd0, 1'b0, 20);
    for (int i = 0; i < nbytes; i++) begin
      if (rd) begin
        run_command(KIND_READ, 8'($urandom_range(255)), 1'($urandom_range(1)), 50);
        run_command(KIND_SACK, 8'($urandom_range(255)), i == nbytes - 1, 50);
      end else begin
        run_command(KIND_WRITE, 8'($urandom_range(255)), 1'($urandom_range(1)), 50);
        run_command(KIND_RACK, 8'($urandom_range(255)), 1'($urandom_range(1)), 20);
      end
    end
    run_command(KIND_STOP, 8'($urandom_range(255)), 1'($urandom_range(1)), 50);
    idle_ticks($urandom_range(0, 3));
  endtask

  // Commands in any order, reserved kind included
  task automatic broken_sequence();
    repeat ($urandom_range(1, 4)) begin
      run_command(3'($urandom_range(1, 7)), 8'($urandom_range(255)),
                  1'($urandom_range(1)), 50);
      idle_ticks($urandom_range(0, 2));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Bus idle levels after reset, plain and reserved kinds
  task automatic test_reset_levels();
    send_tick(KIND_NONE, 8'h00, 1'b0, 1'b0);
    send_tick(KIND_RESERVED, 8'hFF, 1'b1, 1'b1);
    send_tick(KIND_NONE, 8'hFF, 1'b1, 1'b1);
    send_tick(KIND_RESERVED, 8'h00, 1'b0, 1'b0);
  endtask

  // Reset period and the widest period, each cut short by a smaller write
  // in the middle of a phase so the phase ends at once
  task automatic test_slow_settings();
    issue_command(KIND_START, 8'h00, 1'b0);
    repeat (40) noise_tick(50);
    write_half_period(16'd2);
    finish_command(50);
    write_half_period(16'hFFFF);
    issue_command(KIND_WRITE, 8'hA5, 1'b0);
    repeat (30) noise_tick(50);
    write_half_period(16'd1);
    finish_command(50);
  endtask

  // Every command at half period zero (counts as one), data extremes
  task automatic test_each_command();
    write_half_period(16'd0);
    run_command(KIND_START, 8'h00, 1'b0, 50);
    run_command(KIND_WRITE, 8'hFF, 1'b1, 50);
    run_command(KIND_RACK, 8'h00, 1'b0, 100);
    run_command(KIND_WRITE, 8'h00, 1'b0, 50);
    run_command(KIND_RACK, 8'hFF, 1'b1, 0);
    run_command(KIND_READ, 8'h00, 1'b0, 100);
    run_command(KIND_SACK, 8'h00, 1'b0, 50);
    run_command(KIND_READ, 8'hFF, 1'b1, 0);
    run_command(KIND_SACK, 8'hFF, 1'b1, 50);
    run_command(KIND_RESERVED, 8'hFF, 1'b1, 50);
    run_command(KIND_STOP, 8'h00, 1'b0, 50);
  endtask

  // Both sides at full rate: one word per cycle through the block
  task automatic test_back_to_back();
    write_half_period(16'd1);
    sender_full_rate = 1'b1;
    receiver_full_rate = 1'b1;
    repeat (3) bus_transaction();
    sender_full_rate = 1'b0;
    receiver_full_rate = 1'b0;
  endtask

  // Receiver stops for a long stretch while words keep coming
  task automatic test_backpressure();
    sender_full_rate = 1'b1;
    rx_hold_req = 1'b1;
    repeat (2) bus_transaction();
    sender_full_rate = 1'b0;
  endtask

  task automatic test_random_traffic();
    logic [15:0] hp_list [5] = '{16'd1, 16'd2, 16'd0, 16'd3, 16'd5};
    int stop_at;
    foreach (hp_list[i]) begin
      write_half_period(hp_list[i]);
      stop_at = ticks_sent + RANDOM_TICKS;
      while (ticks_sent < stop_at) begin
        if ($urandom_range(99) < 80) bus_transaction();
        else broken_sequence();
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_levels();
    test_slow_settings();
    test_each_command();
    test_back_to_back();
    test_backpressure();
    test_random_traffic();
    drain();
    if (expected_status_q.size() != 0) mismatches++;
    $display("Run covered %0d tick words, %0d commands, %0d result words checked,",
             ticks_sent, commands_issued, status_checked);
    $display("%0d half-period writes incl. zero and 65535, full rate and long hold-off.",
             half_period_writes);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/i2cbe_pkg.sv
hdl/i2cbe_front.sv
hdl/i2cbe_back.sv
hdl/i2c_master_bit_engine.sv
verif/tb_top.sv
